FILE: hw/rtl/dtes_pkg.sv
package dtes_pkg;

    // Field widths.
    localparam int YEAR_W   = 7;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int EPOCH_W  = 32;

    // Year offset from 1969 (0 to 101), month index (0 is January),
    // signed day count since the epoch, seconds into the day.
    localparam int YOFS_W = 7;
    localparam int MIDX_W = 4;
    localparam int DAYS_W = 17;
    localparam int TOD_W  = 17;
    localparam int DBM_W  = 9;

    localparam int unsigned YEAR_PIVOT      = 70;
    localparam int unsigned CENTURY         = 100;
    localparam int unsigned PIVOT_OFS       = 69;     // 1969 - 1900
    localparam int unsigned MONTHS_PER_YEAR = 12;
    localparam int unsigned MONTH_FEB       = 1;
    localparam int unsigned DAYS_PER_YEAR   = 365;
    localparam int unsigned EPOCH_DAY_BIAS  = 366;    // one year from 1969 plus day one
    localparam int unsigned SECS_PER_DAY    = 86400;
    localparam int unsigned SECS_PER_HOUR   = 3600;
    localparam int unsigned SECS_PER_MIN    = 60;

    typedef struct packed {
        logic [YOFS_W-1:0]   year_ofs;
        logic [MIDX_W-1:0]   month_idx;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } norm_t;

    typedef struct packed {
        logic signed [DAYS_W-1:0] days;
        logic [TOD_W-1:0]         tod;
    } count_t;

    // Days in the months before the given month of a common year.
    function automatic logic [DBM_W-1:0] days_before_month(input logic [MIDX_W-1:0] idx);
        logic [DBM_W-1:0] d;
        case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

FILE: hw/rtl/dtes_normalize.sv
module dtes_normalize (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [dtes_pkg::YEAR_W-1:0]    two_digit_year,
    input  logic [dtes_pkg::MONTH_W-1:0]   month_number,
    input  logic [dtes_pkg::DAY_W-1:0]     day_of_month,
    input  logic [dtes_pkg::HOUR_W-1:0]    hour_value,
    input  logic [dtes_pkg::MINUTE_W-1:0]  minute_value,
    input  logic [dtes_pkg::SECOND_W-1:0]  second_value,
    output logic                           out_valid,
    output dtes_pkg::norm_t                out_word
);
    import dtes_pkg::*;

    logic [YOFS_W:0] ofs_base;
    norm_t           norm_next;
    norm_t           norm_reg;
    logic            valid_reg;

    always_comb
    begin
        // Offset of the year from 1969, before the month wraps it.
        if (two_digit_year < YEAR_W'(YEAR_PIVOT))
        begin
            ofs_base = (YOFS_W+1)'(two_digit_year) + (YOFS_W+1)'(CENTURY - PIVOT_OFS);
        end
        else
        begin
            ofs_base = (YOFS_W+1)'(two_digit_year) - (YOFS_W+1)'(PIVOT_OFS);
        end

        norm_next.day    = day_of_month;
        norm_next.hour   = hour_value;
        norm_next.minute = minute_value;
        norm_next.second = second_value;

        if (month_number == '0)
        begin
            norm_next.year_ofs  = YOFS_W'(ofs_base - 1'b1);
            norm_next.month_idx = MIDX_W'(MONTHS_PER_YEAR - 1);
        end
        else if (month_number > MONTH_W'(MONTHS_PER_YEAR))
        begin
            norm_next.year_ofs  = YOFS_W'(ofs_base + 1'b1);
            norm_next.month_idx = month_number - MIDX_W'(MONTHS_PER_YEAR + 1);
        end
        else
        begin
            norm_next.year_ofs  = YOFS_W'(ofs_base);
            norm_next.month_idx = month_number - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        norm_reg <= norm_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = norm_reg;

endmodule

FILE: hw/rtl/dtes_day_count.sv
module dtes_day_count (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  dtes_pkg::norm_t  in_word,
    output logic             out_valid,
    output dtes_pkg::count_t out_word
);
    import dtes_pkg::*;

    logic              leap;
    logic [DAYS_W-1:0] day_sum;
    count_t            count_next;
    count_t            count_reg;
    logic              valid_reg;

    always_comb
    begin
        // Between 1969 and 2070 every fourth year is a leap year; 2000 is one.
        // Year offset 3 is 1972, so leap years have both low bits set.
        leap = (in_word.year_ofs[1:0] == 2'b11);

        // Leap days before the year are offset / 4, counted from 1969.
        day_sum = DAYS_W'(in_word.year_ofs) * DAYS_W'(DAYS_PER_YEAR)
                + DAYS_W'(in_word.year_ofs >> 2)
                + DAYS_W'(days_before_month(in_word.month_idx))
                + DAYS_W'(leap && (in_word.month_idx > MIDX_W'(MONTH_FEB)))
                + DAYS_W'(in_word.day);

        count_next.days = signed'(day_sum - DAYS_W'(EPOCH_DAY_BIAS));
        count_next.tod  = TOD_W'(in_word.hour) * TOD_W'(SECS_PER_HOUR)
                        + TOD_W'(in_word.minute) * TOD_W'(SECS_PER_MIN)
                        + TOD_W'(in_word.second);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = count_reg;

endmodule

FILE: hw/rtl/dtes_scale.sv
module dtes_scale (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  dtes_pkg::count_t             in_word,
    output logic                         done,
    output logic [dtes_pkg::EPOCH_W-1:0] epoch_seconds
);
    import dtes_pkg::*;

    logic [EPOCH_W-1:0] days_ext;
    logic [EPOCH_W-1:0] prod_next;
    logic [EPOCH_W-1:0] prod_reg;
    logic [TOD_W-1:0]   tod_reg;
    logic               prod_valid_reg;
    logic [EPOCH_W-1:0] epoch_next;
    logic [EPOCH_W-1:0] epoch_reg;
    logic               done_reg;

    // A negative day count wraps modulo 2^32 through the sign extension.
    assign days_ext   = {{(EPOCH_W-DAYS_W){in_word.days[DAYS_W-1]}}, in_word.days};
    assign prod_next  = days_ext * EPOCH_W'(SECS_PER_DAY);
    assign epoch_next = prod_reg + EPOCH_W'(tod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= in_valid;
            done_reg       <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        tod_reg   <= in_word.tod;
        epoch_reg <= epoch_next;
    end

    assign done          = done_reg;
    assign epoch_seconds = epoch_reg;

endmodule

FILE: hw/rtl/date_time_to_epoch_seconds_top.sv
// Converts a two-digit year, month, day and time of day into seconds since
// 1970-01-01 00:00:00. A word is taken on every clock edge where start is high;
// busy is always low, so one conversion enters per cycle with no gaps. Each
// result appears on epoch_seconds for one cycle with done high, in the order the
// words were given. The four register stages are month and year normalization,
// the day count and time of day, the multiply by 86400, and the final add. The
// receiver cannot hold results off, and none is needed: every stage advances on
// every clock.
module date_time_to_epoch_seconds_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [dtes_pkg::YEAR_W-1:0]    two_digit_year,
    input  logic [dtes_pkg::MONTH_W-1:0]   month_number,
    input  logic [dtes_pkg::DAY_W-1:0]     day_of_month,
    input  logic [dtes_pkg::HOUR_W-1:0]    hour_value,
    input  logic [dtes_pkg::MINUTE_W-1:0]  minute_value,
    input  logic [dtes_pkg::SECOND_W-1:0]  second_value,
    output logic                           done,
    output logic [dtes_pkg::EPOCH_W-1:0]   epoch_seconds
);
    import dtes_pkg::*;

    logic   in_valid;
    logic   norm_valid;
    norm_t  norm_word;
    logic   count_valid;
    count_t count_word;

    assign busy     = 1'b0;
    assign in_valid = start && !busy;

    dtes_normalize u_normalize (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .two_digit_year (two_digit_year),
        .month_number   (month_number),
        .day_of_month   (day_of_month),
        .hour_value     (hour_value),
        .minute_value   (minute_value),
        .second_value   (second_value),
        .out_valid      (norm_valid),
        .out_word       (norm_word)
    );

    dtes_day_count u_day_count (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (norm_valid),
        .in_word   (norm_word),
        .out_valid (count_valid),
        .out_word  (count_word)
    );

    dtes_scale u_scale (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (count_valid),
        .in_word       (count_word),
        .done          (done),
        .epoch_seconds (epoch_seconds)
    );

    a_start_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("accepted word produced no result four cycles later");

    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result strobe without an accepted word");

    a_epoch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && two_digit_year == YEAR_W'(YEAR_PIVOT)
            && month_number == 4'd1 && day_of_month == 5'd1
            && hour_value == '0 && minute_value == '0 && second_value == '0)
        |-> ##4 (epoch_seconds == '0))
        else $error("start of 1970 did not convert to zero");

endmodule
